FILE: hdl/fsbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsbc_pkg
// Shared constants and byte-level functions of the 128-bit block cipher.
// ----------------------------------------------------------------------------
package fsbc_pkg;

   localparam int MaxRounds  = 14;
   localparam int BlockBytes = 16;
   localparam int BlockBits  = BlockBytes * 8;
   localparam logic [7:0] SboxConst = 8'hCD;
   localparam logic [7:0] GfPoly    = 8'h1B;
   localparam logic [7:0] GfTop     = 8'h80;
   localparam int SchedConsts = 56;

   localparam logic [1:0] CSR_KEY_HI      = 2'd0;
   localparam logic [1:0] CSR_KEY_LO      = 2'd1;
   localparam logic [1:0] CSR_ROUND_COUNT = 2'd2;

   function automatic logic [7:0] gmul(input logic [7:0] a_in, input logic [7:0] b_in);
      logic [7:0] a;
      logic [7:0] p;
      a = a_in;
      p = '0;
      for (int k = 0; k < 8; k++) begin
         if (b_in[k]) p = p ^ a;
         if ((a & GfTop) != 8'h00) a = (a << 1) ^ GfPoly;
         else a = a << 1;
      end
      return p;
   endfunction

   // bytes held big-endian: byte 0 in bits 127:120
   function automatic logic [7:0] byte_of(input logic [BlockBits-1:0] s, input int j);
      return s[BlockBits-1-8*j -: 8];
   endfunction

   function automatic logic [31:0] sbox_fwd(input logic [31:0] c_in);
      logic [7:0] c [4];
      logic [7:0] t;
      for (int j = 0; j < 4; j++) c[j] = c_in[31-8*j -: 8];
      for (int k = 0; k < 4; k++) begin
         t = gmul(c[0], c[1]) ^ c[2] ^ c[3] ^ SboxConst;
         c[3] = c[2]; c[2] = c[1]; c[1] = c[0]; c[0] = t;
      end
      return {c[0], c[1], c[2], c[3]};
   endfunction

   function automatic logic [31:0] sbox_inv(input logic [31:0] c_in);
      logic [7:0] c [4];
      logic [7:0] t;
      for (int j = 0; j < 4; j++) c[j] = c_in[31-8*j -: 8];
      for (int k = 0; k < 4; k++) begin
         t = gmul(c[1], c[2]) ^ c[0] ^ c[3] ^ SboxConst;
         c[0] = c[1]; c[1] = c[2]; c[2] = c[3]; c[3] = t;
      end
      return {c[0], c[1], c[2], c[3]};
   endfunction

   function automatic logic [BlockBits-1:0] lin_fwd(input logic [BlockBits-1:0] s);
      logic [7:0] all;
      logic [BlockBits-1:0] r;
      all = '0;
      for (int j = 0; j < BlockBytes; j++) all = all ^ byte_of(s, j);
      for (int j = 0; j < BlockBytes; j++)
         r[BlockBits-1-8*j -: 8] = all ^ byte_of(s, j) ^ byte_of(s, (j + 4) % 16)
            ^ byte_of(s, (j + 9) % 16) ^ byte_of(s, (j + 10) % 16)
            ^ byte_of(s, (j + 11) % 16);
      return r;
   endfunction

   function automatic logic [BlockBits-1:0] lin_inv(input logic [BlockBits-1:0] s);
      logic [BlockBits-1:0] r;
      for (int j = 0; j < BlockBytes; j++)
         r[BlockBits-1-8*j -: 8] = byte_of(s, j) ^ byte_of(s, (j + 3) % 16)
            ^ byte_of(s, (j + 4) % 16) ^ byte_of(s, (j + 8) % 16)
            ^ byte_of(s, (j + 9) % 16) ^ byte_of(s, (j + 12) % 16)
            ^ byte_of(s, (j + 14) % 16);
      return r;
   endfunction

endpackage

FILE: hdl/feistel_spn_block_cipher_128_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feistel_spn_block_cipher_128_core
// 128-bit SPN/Feistel cipher with round keys kept in two synchronous memories.
// ----------------------------------------------------------------------------
// After the accepting edge: ST_LOAD, ST_ROUND for r = 0..nr (nr = rounds, 1..14),
//   then ST_OUT with rsp_valid; one round per cycle on a shared round unit fed by
//   the key memory. busy stays high through ST_OUT, so one block is done at a time.
// First block after reset or a key or round-count csr write adds key expansion:
//   schedule words, a copy pass and a handoff. Results cannot be stalled.
// Reset (synchronous, active high) sets key = 0, round_count = 12, keys stale.
module feistel_spn_block_cipher_128_core #(
   parameter int MAX_ROUNDS = fsbc_pkg::MaxRounds
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [63:0] req_block_hi,
   input  logic [63:0] req_block_lo,
   output logic        rsp_valid,
   output logic [63:0] rsp_result_hi,
   output logic [63:0] rsp_result_lo,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wr_data
);

   localparam int AW = $clog2(MAX_ROUNDS + 1);
   localparam int BB = fsbc_pkg::BlockBits;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_KEYS  = 5'b00010,
      ST_LOAD  = 5'b00100,
      ST_ROUND = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [63:0] key_hi_ff, key_lo_ff;
   logic [3:0]  rcnt_ff;
   logic        ready_ff, ready_in;
   logic        mode_ff, mode_in;
   logic [BB-1:0] blk_ff, blk_in, st_ff, st_in;
   logic [AW-1:0] r_ff, r_in;
   logic [AW-1:0] nr;
   logic          ks_go, ks_done, ks_enc_wr, ks_dec_wr;
   logic [AW-1:0] ks_wa, ks_ra, rd_addr;
   logic [BB-1:0] ks_wd, enc_rd, dec_rd, rk, sb, lin;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      if (rcnt_ff == 4'd0) nr = AW'(1);
      else if (rcnt_ff > 4'(MAX_ROUNDS)) nr = AW'(MAX_ROUNDS);
      else nr = AW'(rcnt_ff);
   end

   fsbc_key_sched #(.MAX_ROUNDS(MAX_ROUNDS)) u_sched (
      .clock, .reset, .go(ks_go), .key({key_hi_ff, key_lo_ff}), .nr,
      .done(ks_done), .enc_wr(ks_enc_wr), .dec_wr(ks_dec_wr), .wr_addr(ks_wa),
      .wr_data(ks_wd), .rd_addr(ks_ra), .rd_data(enc_rd)
   );

   fsbc_key_mem #(.DEPTH(MAX_ROUNDS + 1)) u_enc_mem (
      .clock, .wr_en(ks_enc_wr), .wr_addr(ks_wa), .wr_data(ks_wd),
      .rd_addr(rd_addr), .rd_data(enc_rd)
   );

   fsbc_key_mem #(.DEPTH(MAX_ROUNDS + 1)) u_dec_mem (
      .clock, .wr_en(ks_dec_wr), .wr_addr(ks_wa), .wr_data(ks_wd),
      .rd_addr(rd_addr), .rd_data(dec_rd)
   );

   assign rk = mode_ff ? dec_rd : enc_rd;

   always_comb begin
      for (int g = 0; g < 4; g++)
         sb[BB-1-32*g -: 32] = mode_ff ? fsbc_pkg::sbox_inv(st_ff[BB-1-32*g -: 32])
                                       : fsbc_pkg::sbox_fwd(st_ff[BB-1-32*g -: 32]);
      if (r_ff == nr) lin = sb;
      else if (mode_ff) lin = fsbc_pkg::lin_inv(sb);
      else lin = fsbc_pkg::lin_fwd(sb);
   end

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      mode_in = mode_ff;
      blk_in = blk_ff;
      st_in = st_ff;
      r_in = r_ff;
      ks_go = 1'b0;
      rsp_valid_in = 1'b0;
      rd_addr = ks_ra;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in = req_mode;
               blk_in = {req_block_hi, req_block_lo};
               if (ready_ff) begin
                  state_in = ST_LOAD;
               end else begin
                  ks_go = 1'b1;
                  state_in = ST_KEYS;
               end
            end
         end
         ST_KEYS: begin
            if (ks_done) begin
               ready_in = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // key 0 is being read; next cycle whitens the block
            rd_addr = '0;
            r_in = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            rd_addr = r_ff + 1'b1;
            if (r_ff == '0) st_in = blk_ff ^ rk;
            else st_in = lin ^ rk;
            r_in = r_ff + 1'b1;
            if (r_ff == nr) begin
               state_in = ST_OUT;
               rsp_valid_in = 1'b1;
            end
         end
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (csr_wr_en && (csr_index == fsbc_pkg::CSR_KEY_HI || csr_index == fsbc_pkg::CSR_KEY_LO
                        || csr_index == fsbc_pkg::CSR_ROUND_COUNT))
         ready_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         key_hi_ff <= '0;
         key_lo_ff <= '0;
         rcnt_ff <= 4'd12;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               fsbc_pkg::CSR_KEY_HI:      key_hi_ff <= csr_wr_data;
               fsbc_pkg::CSR_KEY_LO:      key_lo_ff <= csr_wr_data;
               fsbc_pkg::CSR_ROUND_COUNT: rcnt_ff <= csr_wr_data[3:0];
               default: ;
            endcase
         end
      end
      mode_ff <= mode_in;
      blk_ff <= blk_in;
      st_ff <= st_in;
      r_ff <= r_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_hi = st_ff[BB-1 -: 64];
   assign rsp_result_lo = st_ff[63:0];

endmodule

FILE: hdl/fsbc_key_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsbc_key_mem
// Round key store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fsbc_key_mem #(
   parameter int DEPTH = fsbc_pkg::MaxRounds + 1
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  logic [fsbc_pkg::BlockBits-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0]       rd_addr,
   output logic [fsbc_pkg::BlockBits-1:0] rd_data
);

   logic [fsbc_pkg::BlockBits-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: hdl/fsbc_key_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsbc_key_sched
// Word-serial key expansion: one 32-bit schedule word per cycle, then a
// pass that writes the decryption keys (inner ones through lin_inv).
// ----------------------------------------------------------------------------
module fsbc_key_sched #(
   parameter int MAX_ROUNDS = fsbc_pkg::MaxRounds
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           go,
   input  logic [127:0]                   key,
   input  logic [$clog2(MAX_ROUNDS+1)-1:0] nr,
   output logic                           done,
   output logic                           enc_wr,
   output logic                           dec_wr,
   output logic [$clog2(MAX_ROUNDS+1)-1:0] wr_addr,
   output logic [fsbc_pkg::BlockBits-1:0] wr_data,
   output logic [$clog2(MAX_ROUNDS+1)-1:0] rd_addr,
   input  logic [fsbc_pkg::BlockBits-1:0] rd_data
);

   localparam int AW = $clog2(MAX_ROUNDS + 1);
   localparam int WW = $clog2(4 * MAX_ROUNDS + 1);

   typedef enum logic [3:0] {
      KS_IDLE = 4'b0001,
      KS_WORD = 4'b0010,
      KS_COPY = 4'b0100,
      KS_DONE = 4'b1000
   } ks_state_type;

   ks_state_type state_ff, state_in;
   logic [127:0] win_ff, win_in;      // last four schedule words
   logic [WW-1:0] wi_ff, wi_in;       // schedule word index
   logic [AW:0]   ci_ff, ci_in;       // copy pass address (issue side)
   logic          cv_ff, cv_in;
   logic [AW-1:0] ca_ff, ca_in;

   logic [31:0] x, y, rc, sy, src, nw;
   logic [7:0]  rcb;
   logic [AW-1:0] dst;

   always_comb begin
      x = win_ff[95:64] ^ win_ff[63:32] ^ win_ff[31:0];
      y = {x[7:0], x[31:8]};
      rcb = 8'({wi_ff, 2'b00});
      rc = {rcb + 8'd1, rcb + 8'd2, rcb + 8'd3, rcb + 8'd4};
      sy = fsbc_pkg::sbox_fwd(y);
      src = fsbc_pkg::sbox_fwd(rc);
      nw = sy ^ win_ff[127:96] ^ src;
   end

   always_comb begin
      state_in = state_ff;
      win_in = win_ff;
      wi_in = wi_ff;
      ci_in = ci_ff;
      cv_in = 1'b0;
      ca_in = ca_ff;
      enc_wr = 1'b0;
      dec_wr = 1'b0;
      wr_addr = '0;
      wr_data = win_ff;
      rd_addr = ci_ff[AW-1:0];
      dst = AW'(nr - ca_ff);
      done = (state_ff == KS_DONE);
      unique case (state_ff)
         KS_IDLE: begin
            if (go) begin
               win_in = key;
               wi_in = '0;
               state_in = KS_WORD;
            end
         end
         KS_WORD: begin
            // each full 4-word group completes a round key
            if (wi_ff[1:0] == 2'd0) begin
               enc_wr = 1'b1;
               wr_addr = AW'(wi_ff >> 2);
               wr_data = win_ff;
            end
            if ((wi_ff >> 2) == WW'(nr) || wi_ff == WW'(fsbc_pkg::SchedConsts)) begin
               state_in = KS_COPY;
               ci_in = '0;
            end else begin
               win_in = {win_ff[95:0], nw};
               wi_in = wi_ff + 1'b1;
            end
         end
         KS_COPY: begin
            if (ci_ff <= (AW+1)'(nr)) begin
               cv_in = 1'b1;
               ca_in = ci_ff[AW-1:0];
               ci_in = ci_ff + 1'b1;
            end
            if (cv_ff) begin
               dec_wr = 1'b1;
               wr_addr = dst;
               if (ca_ff == '0 || ca_ff == nr) wr_data = rd_data;
               else wr_data = fsbc_pkg::lin_inv(rd_data);
               if (ca_ff == nr) state_in = KS_DONE;
            end
         end
         KS_DONE: begin
            if (go) begin
               win_in = key;
               wi_in = '0;
               state_in = KS_WORD;
            end
         end
         default: state_in = KS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= KS_IDLE;
         cv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cv_ff <= cv_in;
      end
      win_ff <= win_in;
      wi_ff <= wi_in;
      ci_ff <= ci_in;
      ca_ff <= ca_in;
   end

endmodule

FILE: hdl/fsbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsbc_checker
// Port-level checks of the cipher core handshake and result timing.
// ----------------------------------------------------------------------------
module fsbc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("start not taken");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside an item");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result longer than a beat");

   a_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy held after result");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !busy && !rsp_valid) else $error("not idle after reset");

endmodule

bind feistel_spn_block_cipher_128_core fsbc_checker u_fsbc_checker (
   .clock, .reset, .start, .busy, .rsp_valid
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 128-bit block cipher core. Blocks are pushed
// through the start/busy handshake under several key and round settings.
// Every result beat is compared with a behavioral cipher model kept in the
// bench.
// ----------------------------------------------------------------------------
module tb_top;

   typedef logic [15:0][7:0] state_type;   // [15] is byte 0

   typedef struct {
      logic        mode;
      logic [63:0] hi;
      logic [63:0] lo;
   } blk_row_type;

   // index past the register list, written to check it is dropped
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_mode;
   logic [63:0] req_block_hi;
   logic [63:0] req_block_lo;
   logic        rsp_valid;
   logic [63:0] rsp_result_hi;
   logic [63:0] rsp_result_lo;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [63:0] csr_wr_data;

   // bench copy of the register file
   logic [63:0] cfg_key_hi;
   logic [63:0] cfg_key_lo;
   logic [3:0]  cfg_rounds;

   logic [127:0] cipher_q [$];
   int           fail_cnt;
   int           beat_cnt;
   int           dec_cnt;

   feistel_spn_block_cipher_128_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_block_hi(req_block_hi), .req_block_lo(req_block_lo),
      .rsp_valid(rsp_valid), .rsp_result_hi(rsp_result_hi),
      .rsp_result_lo(rsp_result_lo), .csr_wr_en(csr_wr_en), .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------- cipher model ----------------
   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      acc = 8'h00;
      x = a;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) acc ^= x;
         x = x[7] ? ((x << 1) ^ fsbc_pkg::GfPoly) : (x << 1);
      end
      return acc;
   endfunction

   function automatic logic [31:0] feistel_enc(input logic [31:0] v);
      logic [7:0] c0, c1, c2, c3, t;
      {c0, c1, c2, c3} = v;
      for (int k = 0; k < 4; k++) begin
         t = gf_mul(c0, c1) ^ c2 ^ c3 ^ fsbc_pkg::SboxConst;
         c3 = c2; c2 = c1; c1 = c0; c0 = t;
      end
      return {c0, c1, c2, c3};
   endfunction

   function automatic logic [31:0] feistel_dec(input logic [31:0] v);
      logic [7:0] c0, c1, c2, c3, t;
      {c0, c1, c2, c3} = v;
      for (int k = 0; k < 4; k++) begin
         t = gf_mul(c1, c2) ^ c0 ^ c3 ^ fsbc_pkg::SboxConst;
         c0 = c1; c1 = c2; c2 = c3; c3 = t;
      end
      return {c0, c1, c2, c3};
   endfunction

   function automatic state_type diffuse_fwd(input state_type s);
      state_type r;
      logic [7:0] par;
      par = 8'h00;
      for (int j = 0; j < 16; j++) par ^= s[15-j];
      for (int j = 0; j < 16; j++)
         r[15-j] = par ^ s[15-j] ^ s[15-(j+4)%16] ^ s[15-(j+9)%16]
                   ^ s[15-(j+10)%16] ^ s[15-(j+11)%16];
      return r;
   endfunction

   function automatic state_type diffuse_inv(input state_type s);
      state_type r;
      for (int j = 0; j < 16; j++)
         r[15-j] = s[15-j] ^ s[15-(j+3)%16] ^ s[15-(j+4)%16] ^ s[15-(j+8)%16]
                   ^ s[15-(j+9)%16] ^ s[15-(j+12)%16] ^ s[15-(j+14)%16];
      return r;
   endfunction

   function automatic logic [127:0] cipher_block(input logic mode, input logic [63:0] hi,
                                                 input logic [63:0] lo);
      logic [7:0] w [240];
      state_type  rk [15];
      state_type  s, k;
      logic [31:0] x, y, rc;
      int nr;
      nr = cfg_rounds;
      if (nr < 1) nr = 1;
      if (nr > fsbc_pkg::MaxRounds) nr = fsbc_pkg::MaxRounds;
      for (int j = 0; j < 240; j++) w[j] = 8'h00;
      for (int j = 0; j < 8; j++) begin
         w[j]     = cfg_key_hi[63-8*j -: 8];
         w[8 + j] = cfg_key_lo[63-8*j -: 8];
      end
      for (int i = 0; i < nr * 4 && i < fsbc_pkg::SchedConsts; i++) begin
         for (int j = 0; j < 4; j++) begin
            x[31-8*j -: 8]  = w[4*i+4+j] ^ w[4*i+8+j] ^ w[4*i+12+j];
            rc[31-8*j -: 8] = 8'(4 * i + j + 1);
         end
         y = feistel_enc({x[7:0], x[31:8]});   // word rotated right one byte
         rc = feistel_enc(rc);
         for (int j = 0; j < 4; j++)
            w[4*i+16+j] = y[31-8*j -: 8] ^ w[4*i+j] ^ rc[31-8*j -: 8];
      end
      for (int i = 0; i <= nr; i++)
         for (int j = 0; j < 16; j++) rk[i][15-j] = w[16*i+j];
      s = {hi, lo};
      for (int r = 0; r <= nr; r++) begin
         if (!mode) k = rk[r];
         else if (r == 0) k = rk[nr];
         else if (r == nr) k = rk[0];
         else k = diffuse_inv(rk[nr-r]);
         if (r > 0) begin
            for (int g = 0; g < 4; g++)
               s[15-4*g -: 4] = mode ? feistel_dec(s[15-4*g -: 4])
                                     : feistel_enc(s[15-4*g -: 4]);
            if (r < nr) s = mode ? diffuse_inv(s) : diffuse_fwd(s);
         end
         s ^= k;
      end
      return s;
   endfunction

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      logic [127:0] want;
      if (!reset && rsp_valid) begin
         beat_cnt++;
         if (cipher_q.size() == 0) begin
            $display("%0t: unexpected result beat %h_%h", $time, rsp_result_hi,
                     rsp_result_lo);
            fail_cnt++;
         end else begin
            want = cipher_q.pop_front();
            if (rsp_result_hi !== want[127:64]) begin
               $display("%0t: result_hi expected %h actual %h", $time, want[127:64],
                        rsp_result_hi);
               fail_cnt++;
            end
            if (rsp_result_lo !== want[63:0]) begin
               $display("%0t: result_lo expected %h actual %h", $time, want[63:0],
                        rsp_result_lo);
               fail_cnt++;
            end
         end
      end
   end

   // ---------------- drivers ----------------
   task automatic csr_write(input logic [1:0] idx, input logic [63:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         fsbc_pkg::CSR_KEY_HI:      cfg_key_hi = data;
         fsbc_pkg::CSR_KEY_LO:      cfg_key_lo = data;
         fsbc_pkg::CSR_ROUND_COUNT: cfg_rounds = data[3:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain;
      start <= 1'b0;
      while (cipher_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // start stays high after a beat is taken so a zero gap needs no second
   // assignment in the same step; busy keeps the core from taking it again
   task automatic send_block(input logic mode, input logic [63:0] hi, input logic [63:0] lo,
                             input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_mode     <= mode;
      req_block_hi <= hi;
      req_block_lo <= lo;
      do @(posedge clock); while (busy);
      cipher_q.push_back(cipher_block(mode, hi, lo));
      if (mode) dec_cnt++;
   endtask

   function automatic int rand_gap();
      int p;
      p = $urandom_range(99);
      if (p < 60) return 0;
      if (p < 93) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [63:0] rand64();
      logic [63:0] v;
      int p;
      v = {$urandom, $urandom};
      p = $urandom_range(9);
      if (p == 0) v = '0;
      if (p == 1) v = '1;
      return v;
   endfunction

   blk_row_type dir_rows [] = '{
      '{1'b0, 64'h0, 64'h0},
      '{1'b1, 64'h0, 64'h0},
      '{1'b0, '1, '1},
      '{1'b1, '1, '1},
      '{1'b0, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001},
      '{1'b1, 64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000},
      '{1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555},
      '{1'b1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA},
      '{1'b0, 64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF},
      '{1'b1, 64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF}
   };

   // round settings walked by the random phases; 0 and 15 clamp to 1 and 14
   logic [3:0] rounds_list [] = '{4'd1, 4'd14, 4'd0, 4'd15, 4'd12, 4'd2, 4'd7, 4'd3};

   initial begin
      int total;
      fail_cnt = 0; beat_cnt = 0; dec_cnt = 0; total = 0;
      cfg_key_hi = '0; cfg_key_lo = '0; cfg_rounds = 4'd12;
      reset <= 1'b1; start <= 1'b0; req_mode <= 1'b0;
      req_block_hi <= '0; req_block_lo <= '0;
      csr_wr_en <= 1'b0; csr_index <= fsbc_pkg::CSR_KEY_HI; csr_wr_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset key, then all-ones key with 1 and 14 rounds
      for (int pass = 0; pass < 3; pass++) begin
         if (pass == 1) begin
            csr_write(fsbc_pkg::CSR_KEY_HI, '1);
            csr_write(fsbc_pkg::CSR_KEY_LO, '1);
            csr_write(fsbc_pkg::CSR_ROUND_COUNT, 64'd1);
         end
         if (pass == 2) begin
            csr_write(fsbc_pkg::CSR_ROUND_COUNT, 64'hFFFF_FFFF_FFFF_FFF0 | 64'd14);
            csr_write(CSR_UNUSED, '1);   // no such register: dropped
         end
         for (int i = 0; i < (pass == 0 ? dir_rows.size() : 6); i++) begin
            send_block(dir_rows[i].mode, dir_rows[i].hi, dir_rows[i].lo, i % 3);
            total++;
         end
         drain();
      end

      // random phases, each under a fresh setting
      for (int ph = 0; ph < 10; ph++) begin
         csr_write(fsbc_pkg::CSR_KEY_HI, rand64());
         csr_write(fsbc_pkg::CSR_KEY_LO, rand64());
         csr_write(fsbc_pkg::CSR_ROUND_COUNT,
                   {$urandom, $urandom} & ~64'hF | rounds_list[ph % rounds_list.size()]);
         if ($urandom_range(3) == 0) csr_write(CSR_UNUSED, rand64());
         for (int i = 0; i < 125; i++) begin
            send_block($urandom_range(1), rand64(), rand64(), rand_gap());
            total++;
            if (ph == 4 && i == 60) drain();   // let the pipe empty mid-phase
         end
         drain();
      end

      drain();
      repeat (40) @(posedge clock);
      $display("Ran %0d blocks (%0d decrypt) over 13 key/round settings, %0d beats seen.",
               total, dec_cnt, beat_cnt);
      if (fail_cnt == 0 && cipher_q.size() == 0) begin
         $display("[feistel_spn_block_cipher_128_core] OK");
      end else begin
         $display("%0d mismatches, %0d results outstanding", fail_cnt, cipher_q.size());
         $display("[feistel_spn_block_cipher_128_core] ERROR");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("%0t: timeout", $time);
      $display("[feistel_spn_block_cipher_128_core] ERROR");
      $finish;
   end

endmodule

FILE: feistel_spn_block_cipher_128_core.f
hdl/fsbc_pkg.sv
hdl/fsbc_key_mem.sv
hdl/fsbc_key_sched.sv
hdl/feistel_spn_block_cipher_128_core.sv
hdl/fsbc_checker.sv
tb/tb_top.sv
